// ===== rtl/tbsm_pkg.sv =====
// shared types, codes and widths for the triple buffer slot manager
package tbsm_pkg;

  // default number of frame slots
  localparam int SLOT_COUNT_DEF = 3;

  // field widths
  localparam int FUNC_W  = 2;
  localparam int DIM_W   = 16;
  localparam int FNUM_W  = 32;
  localparam int INDEX_W = 3;

  // stream word widths, padded to whole bytes
  localparam int IN_BITS   = DIM_W + DIM_W + FNUM_W + INDEX_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = 1 + INDEX_W + DIM_W + DIM_W + FNUM_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUBLISH = 2'd0,
    FUNC_ACQUIRE = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_t;

  // slot status codes
  typedef enum logic [1:0] {
    SLOT_FREE      = 2'd0,
    SLOT_PUBLISHED = 2'd1,
    SLOT_INFLIGHT  = 2'd2
  } slot_status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

// ===== rtl/triple_buffer_slot_manager_unit.sv =====
// top level of the triple buffer slot manager
//
// A producer and a display consumer share SLOT_COUNT frame slots. Each word on
// the s_ channel is one request: publish a frame, acquire the newest frame,
// release a slot, or clear all slots. Each request gives exactly one result
// word on the m_ channel, holding the accepted flag, the slot index and, for
// an acquire, the frame size and frame number.
// A request is taken when s_tvalid and s_tready are high; the slot table is
// updated in the following cycle and the result word shows on m_tvalid the
// cycle after that. One request is in work at a time: s_tready returns the
// cycle after the result is taken, so each request passes through the accept
// cycle, the cycle that updates the table and loads the result register, and
// the cycle that hands the result word out.
// If the receiver stalls, the result word holds on m_tdata and no new request
// is taken until it is taken.
// Reset (rst, synchronous) frees all slots, drops the newest-frame marker and
// leaves the block ready for a request.
module triple_buffer_slot_manager_unit #(
  parameter int SLOT_COUNT = tbsm_pkg::SLOT_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // slave side: width, height, frame_number, release_index
  input  logic [tbsm_pkg::IN_DATA_W-1:0]      s_tdata,
  // func
  input  logic [tbsm_pkg::FUNC_W-1:0]         s_tuser,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // master side: accepted, slot_index, out_width, out_height, out_frame_number
  output logic [tbsm_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready
);
  import tbsm_pkg::*;

  ctrl_cmd_t          cmd;
  logic               accepted;
  logic [INDEX_W-1:0] slot_index;
  logic [DIM_W-1:0]   out_width;
  logic [DIM_W-1:0]   out_height;
  logic [FNUM_W-1:0]  out_frame_number;

  // sequencer
  tbsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // slot table and result
  tbsm_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .in_func          (s_tuser),
    .in_frame_width   (s_tdata[DIM_W-1:0]),
    .in_frame_height  (s_tdata[2*DIM_W-1:DIM_W]),
    .in_frame_number  (s_tdata[2*DIM_W+FNUM_W-1:2*DIM_W]),
    .in_release_index (s_tdata[IN_BITS-1:2*DIM_W+FNUM_W]),
    .accepted         (accepted),
    .slot_index       (slot_index),
    .out_width        (out_width),
    .out_height       (out_height),
    .out_frame_number (out_frame_number)
  );

  // pack the result word
  assign m_tdata = {{(OUT_DATA_W-OUT_BITS){1'b0}}, out_frame_number, out_height,
                    out_width, slot_index, accepted};

endmodule

// ===== rtl/tbsm_ctrl.sv =====
// handshake sequencer for the triple buffer slot manager
module tbsm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output tbsm_pkg::ctrl_cmd_t cmd
);
  import tbsm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEND
  } state_t;

  state_t state;

  // datapath commands
  assign cmd.load = s_tvalid && s_tready;
  assign cmd.exec = (state == ST_EXEC);

  // state and handshake registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s_tready <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            state    <= ST_EXEC;
            s_tready <= 1'b0;
          end
        end
        ST_EXEC: begin
          state    <= ST_SEND;
          m_tvalid <= 1'b1;
        end
        ST_SEND: begin
          if (m_tready) begin
            state    <= ST_IDLE;
            m_tvalid <= 1'b0;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_IDLE;
          s_tready <= 1'b1;
          m_tvalid <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/tbsm_dp.sv =====
// slot table, selection logic and result register
module tbsm_dp #(
  parameter int SLOT_COUNT = tbsm_pkg::SLOT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tbsm_pkg::ctrl_cmd_t             cmd,
  input  logic [tbsm_pkg::FUNC_W-1:0]     in_func,
  input  logic [tbsm_pkg::DIM_W-1:0]      in_frame_width,
  input  logic [tbsm_pkg::DIM_W-1:0]      in_frame_height,
  input  logic [tbsm_pkg::FNUM_W-1:0]     in_frame_number,
  input  logic [tbsm_pkg::INDEX_W-1:0]    in_release_index,
  output logic                            accepted,
  output logic [tbsm_pkg::INDEX_W-1:0]    slot_index,
  output logic [tbsm_pkg::DIM_W-1:0]      out_width,
  output logic [tbsm_pkg::DIM_W-1:0]      out_height,
  output logic [tbsm_pkg::FNUM_W-1:0]     out_frame_number
);
  import tbsm_pkg::*;

  // latched request
  func_t              req_func;
  logic [DIM_W-1:0]   req_width;
  logic [DIM_W-1:0]   req_height;
  logic [FNUM_W-1:0]  req_fnum;
  logic [INDEX_W-1:0] req_rel;

  // slot table
  slot_status_t       status [SLOT_COUNT];
  logic [DIM_W-1:0]   slot_w [SLOT_COUNT];
  logic [DIM_W-1:0]   slot_h [SLOT_COUNT];
  logic [FNUM_W-1:0]  slot_fn [SLOT_COUNT];
  logic [INDEX_W-1:0] newest_index;
  logic               newest_valid;
  logic               newest_taken;

  // selection results
  logic               free_any;
  logic [INDEX_W-1:0] pick;
  logic               newest_pub;
  logic               rel_hit;
  logic [DIM_W-1:0]   sel_w;
  logic [DIM_W-1:0]   sel_h;
  logic [FNUM_W-1:0]  sel_fn;
  logic               pub_ok;
  logic               acq_ok;
  logic               drop_old;

  // capture the request word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func   <= func_t'(in_func);
      req_width  <= in_frame_width;
      req_height <= in_frame_height;
      req_fnum   <= in_frame_number;
      req_rel    <= in_release_index;
    end
  end

  // lowest free slot, newest slot lookup, release match
  always_comb begin
    free_any   = 1'b0;
    pick       = '0;
    newest_pub = 1'b0;
    rel_hit    = 1'b0;
    sel_w      = '0;
    sel_h      = '0;
    sel_fn     = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (status[i] == SLOT_FREE) begin
        free_any = 1'b1;
        pick     = INDEX_W'(i);
      end
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (newest_index == INDEX_W'(i)) begin
        newest_pub = (status[i] == SLOT_PUBLISHED);
        sel_w      = slot_w[i];
        sel_h      = slot_h[i];
        sel_fn     = slot_fn[i];
      end
      if (req_rel == INDEX_W'(i) && status[i] == SLOT_INFLIGHT) begin
        rel_hit = 1'b1;
      end
    end
    pub_ok   = (req_width != '0) && (req_height != '0) && free_any;
    acq_ok   = newest_valid && !newest_taken && newest_pub;
    drop_old = acq_ok && (newest_index != pick);
  end

  // slot table update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) status[i] <= SLOT_FREE;
      newest_index <= '0;
      newest_valid <= 1'b0;
      newest_taken <= 1'b0;
    end else if (cmd.exec) begin
      case (req_func)
        FUNC_PUBLISH: begin
          if (pub_ok) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (pick == INDEX_W'(i)) begin
                status[i]  <= SLOT_PUBLISHED;
                slot_w[i]  <= req_width;
                slot_h[i]  <= req_height;
                slot_fn[i] <= req_fnum;
              end else if (drop_old && newest_index == INDEX_W'(i)) begin
                status[i] <= SLOT_FREE;
              end
            end
            newest_index <= pick;
            newest_valid <= 1'b1;
            newest_taken <= 1'b0;
          end
        end
        FUNC_ACQUIRE: begin
          if (acq_ok) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (newest_index == INDEX_W'(i)) status[i] <= SLOT_INFLIGHT;
            end
            newest_taken <= 1'b1;
          end
        end
        FUNC_RELEASE: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (req_rel == INDEX_W'(i) && status[i] == SLOT_INFLIGHT) begin
              status[i] <= SLOT_FREE;
            end
          end
        end
        FUNC_CLEAR: begin
          for (int i = 0; i < SLOT_COUNT; i++) status[i] <= SLOT_FREE;
          newest_index <= '0;
          newest_valid <= 1'b0;
          newest_taken <= 1'b0;
        end
        default: begin
          newest_valid <= newest_valid;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      accepted         <= 1'b0;
      slot_index       <= '0;
      out_width        <= '0;
      out_height       <= '0;
      out_frame_number <= '0;
      case (req_func)
        FUNC_PUBLISH: begin
          if (pub_ok) begin
            accepted   <= 1'b1;
            slot_index <= pick;
          end
        end
        FUNC_ACQUIRE: begin
          if (acq_ok) begin
            accepted         <= 1'b1;
            slot_index       <= newest_index;
            out_width        <= sel_w;
            out_height       <= sel_h;
            out_frame_number <= sel_fn;
          end
        end
        FUNC_RELEASE: begin
          accepted <= rel_hit;
        end
        default: begin
          accepted <= 1'b0;
        end
      endcase
    end
  end

endmodule
